// ===== rtl/lc3b_pkg.sv =====
// shared types and constants for the lc3b instruction executor
`timescale 1ns / 1ps
`default_nettype none

package lc3b_pkg;

  // main memory size in words, a power of two between 256 and 32768
  localparam int unsigned MEM_WORDS = 32768;
  localparam int unsigned MEM_AW    = $clog2(MEM_WORDS);
  localparam int unsigned NUM_REGS  = 8;
  localparam int unsigned REG_AW    = $clog2(NUM_REGS);

  // condition codes as {n, z, p}
  localparam logic [2:0] FLAGS_N = 3'b100;
  localparam logic [2:0] FLAGS_Z = 3'b010;
  localparam logic [2:0] FLAGS_P = 3'b001;

  typedef enum logic [1:0] {
    ACT_LOAD    = 2'd0,
    ACT_RESTART = 2'd1,
    ACT_EXEC    = 2'd2,
    ACT_NONE    = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    MW_NONE = 2'd0,
    MW_BYTE = 2'd1,
    MW_WORD = 2'd2
  } memw_e;

  typedef enum logic [3:0] {
    OP_BR   = 4'd0,
    OP_ADD  = 4'd1,
    OP_LDB  = 4'd2,
    OP_STB  = 4'd3,
    OP_JSR  = 4'd4,
    OP_AND  = 4'd5,
    OP_LDW  = 4'd6,
    OP_STW  = 4'd7,
    OP_RTI  = 4'd8,
    OP_XOR  = 4'd9,
    OP_RSV1 = 4'd10,
    OP_RSV2 = 4'd11,
    OP_JMP  = 4'd12,
    OP_SHF  = 4'd13,
    OP_LEA  = 4'd14,
    OP_TRAP = 4'd15
  } op_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_START,
    ST_DEC,
    ST_EXEC,
    ST_MEM
  } state_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [14:0] word_address;
    logic [15:0] word_data;
  } in_t;

  typedef struct packed {
    logic [15:0] program_counter;
    logic        flag_negative;
    logic        flag_zero;
    logic        flag_positive;
    logic        halted;
    logic        reg_written;
    logic [2:0]  reg_index;
    logic [15:0] reg_value;
    memw_e       mem_written;
    logic [15:0] mem_byte_address;
    logic [15:0] mem_value;
  } out_t;

endpackage

`default_nettype wire

// ===== rtl/lc3b_ram.sv =====
// generic single-clock ram with one write port and one registered read port
`timescale 1ns / 1ps
`default_nettype none

module lc3b_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/lc3b_instruction_executor_top.sv =====
// lc3b executor: sequencer around main memory and register file rams
// sequence: an accepted request is registered and run in the start state; load,
// restart, action 3 and a halted execute finish there, other executes go on to
// decode (instruction word in, register read) and execute, and loads, byte
// store and trap then to a memory state, as the single main memory port serves
// the fetch, then one data read or write; a new request waits for idle with no pending result
// reset: a clearing pass writes zero to all MEM_WORDS memory words, one per cycle,
// with no request accepted; config writes are taken throughout
`timescale 1ns / 1ps
`default_nettype none

module lc3b_instruction_executor_top
  import lc3b_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire in_t         in_req_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output out_t             out_res_o,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i
);

  state_e              state_q, state_d;
  in_t                 req_q;
  logic [15:0]         ir_q, ir_d;
  logic [15:0]         pc_q, pc_d;
  logic [2:0]          flags_q, flags_d;
  logic [NUM_REGS-1:0] rvalid_q, rvalid_d;
  logic [15:0]         addr_q, addr_d;
  logic [15:0]         npc_q, npc_d;
  logic [MEM_AW-1:0]   clr_q, clr_d;
  logic [15:0]         start_pc_q;
  out_t                pend_q, pend_d;
  logic                pend_valid_q, pend_valid_d;
  out_t                out_q;
  logic                out_valid_q;
  logic                out_move;

  logic              mem_we, mem_re;
  logic [MEM_AW-1:0] mem_waddr, mem_raddr;
  logic [15:0]       mem_wdata, mem_rdata;
  logic              rf_we, rf_re;
  logic [REG_AW-1:0] rf_waddr, rfa_raddr, rfb_raddr;
  logic [15:0]       rf_wdata, rfa_rdata, rfb_rdata;

  // operands and decoded fields
  op_e         op;
  logic [15:0] a_val, rb_val, b_val, npc, br_off, jsr_off, sx6, sx6w, shf_res;
  logic [7:0]  ld_byte;
  logic        br_take;

  assign op      = op_e'(ir_q[15:12]);
  assign a_val   = rvalid_q[ir_q[8:6]] ? rfa_rdata : 16'h0000;
  assign rb_val  = rvalid_q[rfb_raddr] ? rfb_rdata : 16'h0000;
  assign b_val   = ir_q[5] ? {{11{ir_q[4]}}, ir_q[4:0]} : rb_val;
  assign npc     = pc_q + 16'd2;
  assign br_off  = {{6{ir_q[8]}}, ir_q[8:0], 1'b0};
  assign jsr_off = {{4{ir_q[10]}}, ir_q[10:0], 1'b0};
  assign sx6     = {{10{ir_q[5]}}, ir_q[5:0]};
  assign sx6w    = {{9{ir_q[5]}}, ir_q[5:0], 1'b0};
  assign br_take = (ir_q[11] & flags_q[2]) | (ir_q[10] & flags_q[1]) |
                   (ir_q[9] & flags_q[0]);
  assign ld_byte = addr_q[0] ? mem_rdata[15:8] : mem_rdata[7:0];

  // shifter
  always_comb begin
    if (!ir_q[4]) begin
      shf_res = a_val << ir_q[3:0];
    end else if (ir_q[5]) begin
      shf_res = $unsigned($signed(a_val) >>> ir_q[3:0]);
    end else begin
      shf_res = a_val >> ir_q[3:0];
    end
  end

  function automatic logic [2:0] cc_of(input logic [15:0] v);
    if (v == 16'h0000) begin
      return FLAGS_Z;
    end else if (v[15]) begin
      return FLAGS_N;
    end
    return FLAGS_P;
  endfunction

  logic        fin, halt, wr, setcc;
  logic [2:0]  wdr;
  logic [15:0] wval;
  memw_e       mw;
  logic [15:0] ma, mv;

  // sequencer next state and memory controls
  always_comb begin
    state_d   = state_q;
    pc_d      = pc_q;
    flags_d   = flags_q;
    rvalid_d  = rvalid_q;
    ir_d      = ir_q;
    addr_d    = addr_q;
    npc_d     = npc_q;
    clr_d     = clr_q;
    mem_we    = 1'b0;
    mem_waddr = clr_q;
    mem_wdata = 16'h0000;
    mem_re    = 1'b0;
    mem_raddr = pc_q[MEM_AW:1];
    rf_re     = 1'b0;
    rfa_raddr = mem_rdata[8:6];
    rfb_raddr = ir_q[2:0];
    fin       = 1'b0;
    halt      = 1'b0;
    wr        = 1'b0;
    setcc     = 1'b0;
    wdr       = ir_q[11:9];
    wval      = 16'h0000;
    mw        = MW_NONE;
    ma        = 16'h0000;
    mv        = 16'h0000;
    case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
        clr_d  = clr_q + 1'b1;
        if (clr_q == MEM_AW'(MEM_WORDS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          state_d = ST_START;
        end
      end
      ST_START: begin
        case (action_e'(req_q.action))
          ACT_LOAD: begin
            mem_we    = 1'b1;
            mem_waddr = req_q.word_address[MEM_AW-1:0];
            mem_wdata = req_q.word_data;
            fin       = 1'b1;
          end
          ACT_RESTART: begin
            rvalid_d = '0;
            pc_d     = start_pc_q;
            flags_d  = FLAGS_Z;
            fin      = 1'b1;
          end
          ACT_EXEC: begin
            if (pc_q == 16'h0000) begin
              halt = 1'b1;
              fin  = 1'b1;
            end else begin
              mem_re  = 1'b1;
              state_d = ST_DEC;
            end
          end
          default: fin = 1'b1;
        endcase
      end
      ST_DEC: begin
        // instruction word arrives, read both register operands
        ir_d  = mem_rdata;
        rf_re = 1'b1;
        if (mem_rdata[15:12] == OP_STB || mem_rdata[15:12] == OP_STW) begin
          rfb_raddr = mem_rdata[11:9];
        end else begin
          rfb_raddr = mem_rdata[2:0];
        end
        state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (op == OP_STB || op == OP_STW) begin
          rfb_raddr = ir_q[11:9];
        end
        fin  = 1'b1;
        pc_d = npc;
        case (op)
          OP_BR: begin
            if (br_take) begin
              pc_d = npc + br_off;
            end
          end
          OP_ADD: begin
            wr = 1'b1; setcc = 1'b1; wval = a_val + b_val;
          end
          OP_AND: begin
            wr = 1'b1; setcc = 1'b1; wval = a_val & b_val;
          end
          OP_XOR: begin
            wr = 1'b1; setcc = 1'b1; wval = a_val ^ b_val;
          end
          OP_SHF: begin
            wr = 1'b1; setcc = 1'b1; wval = shf_res;
          end
          OP_LEA: begin
            wr = 1'b1; wval = npc + br_off;
          end
          OP_JMP: pc_d = a_val;
          OP_JSR: begin
            wr = 1'b1; wdr = 3'd7; wval = npc;
            pc_d = ir_q[11] ? (npc + jsr_off) : a_val;
          end
          OP_STW: begin
            addr_d    = (a_val + sx6w) & 16'hFFFE;
            mem_we    = 1'b1;
            mem_waddr = addr_d[MEM_AW:1];
            mem_wdata = rb_val;
            mw = MW_WORD; ma = addr_d; mv = rb_val;
          end
          OP_LDB, OP_STB, OP_LDW: begin
            fin       = 1'b0;
            pc_d      = pc_q;
            npc_d     = npc;
            addr_d    = (op == OP_LDW) ? (a_val + sx6w) : (a_val + sx6);
            mem_re    = 1'b1;
            mem_raddr = addr_d[MEM_AW:1];
            state_d   = ST_MEM;
          end
          OP_TRAP: begin
            fin       = 1'b0;
            pc_d      = pc_q;
            npc_d     = npc;
            mem_re    = 1'b1;
            mem_raddr = MEM_AW'(ir_q[7:0]);
            state_d   = ST_MEM;
          end
          default: ;
        endcase
      end
      ST_MEM: begin
        if (op == OP_STB) begin
          rfb_raddr = ir_q[11:9];
        end
        fin  = 1'b1;
        pc_d = npc_q;
        case (op)
          OP_LDB: begin
            wr = 1'b1; setcc = 1'b1; wval = {{8{ld_byte[7]}}, ld_byte};
          end
          OP_LDW: begin
            wr = 1'b1; setcc = 1'b1; wval = mem_rdata;
          end
          OP_STB: begin
            // read-modify-write of the addressed byte lane
            mem_we    = 1'b1;
            mem_waddr = addr_q[MEM_AW:1];
            mem_wdata = addr_q[0] ? {rb_val[7:0], mem_rdata[7:0]}
                                  : {mem_rdata[15:8], rb_val[7:0]};
            mw = MW_BYTE; ma = addr_q; mv = {8'h00, rb_val[7:0]};
          end
          OP_TRAP: begin
            wr = 1'b1; wdr = 3'd7; wval = npc_q;
            pc_d = mem_rdata;
          end
          default: ;
        endcase
      end
      default: state_d = ST_IDLE;
    endcase
    if (wr) begin
      rvalid_d[wdr] = 1'b1;
    end
    if (setcc) begin
      flags_d = cc_of(wval);
    end
    if (fin) begin
      state_d = ST_IDLE;
    end
  end

  assign rf_we    = wr;
  assign rf_waddr = wdr;
  assign rf_wdata = wval;

  // result assembly and two-entry output buffering
  assign out_move = pend_valid_q && (!out_valid_q || out_ready_i);

  always_comb begin
    pend_d       = pend_q;
    pend_valid_d = pend_valid_q;
    if (out_move) begin
      pend_valid_d = 1'b0;
    end
    if (fin) begin
      pend_valid_d            = 1'b1;
      pend_d.program_counter  = pc_d;
      pend_d.flag_negative    = flags_d[2];
      pend_d.flag_zero        = flags_d[1];
      pend_d.flag_positive    = flags_d[0];
      pend_d.halted           = halt;
      pend_d.reg_written      = wr;
      pend_d.reg_index        = wr ? wdr : 3'd0;
      pend_d.reg_value        = wval;
      pend_d.mem_written      = mw;
      pend_d.mem_byte_address = ma;
      pend_d.mem_value        = mv;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE) && !pend_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_q        <= '0;
      pc_q         <= 16'h0000;
      flags_q      <= FLAGS_Z;
      rvalid_q     <= '0;
      start_pc_q   <= 16'h0000;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      clr_q        <= clr_d;
      pc_q         <= pc_d;
      flags_q      <= flags_d;
      rvalid_q     <= rvalid_d;
      pend_valid_q <= pend_valid_d;
      if (cfg_we_i) begin
        start_pc_q <= cfg_wdata_i;
      end
      if (out_move) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    ir_q   <= ir_d;
    addr_q <= addr_d;
    npc_q  <= npc_d;
    pend_q <= pend_d;
    if (in_valid_i && in_ready_o) begin
      req_q <= in_req_i;
    end
    if (out_move) begin
      out_q <= pend_q;
    end
  end

  // main memory
  lc3b_ram #(
    .Width(16),
    .Depth(MEM_WORDS)
  ) u_main_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  // register file, two copies for two read ports
  lc3b_ram #(
    .Width(16),
    .Depth(NUM_REGS)
  ) u_rf_a (
    .clk_i  (clk_i),
    .we_i   (rf_we),
    .waddr_i(rf_waddr),
    .wdata_i(rf_wdata),
    .re_i   (rf_re),
    .raddr_i(rfa_raddr),
    .rdata_o(rfa_rdata)
  );

  lc3b_ram #(
    .Width(16),
    .Depth(NUM_REGS)
  ) u_rf_b (
    .clk_i  (clk_i),
    .we_i   (rf_we),
    .waddr_i(rf_waddr),
    .wdata_i(rf_wdata),
    .re_i   (rf_re),
    .raddr_i(rfb_raddr),
    .rdata_o(rfb_rdata)
  );

  // checks
  a_accept_starts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_START))
    else $error("accepted request did not start the sequencer");

  a_exec_after_dec : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC) |-> ($past(state_q) == ST_DEC))
    else $error("execute stage entered without decode");

  a_halt_quiet : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_valid_q && pend_q.halted) |-> (!pend_q.reg_written &&
      pend_q.mem_written == MW_NONE))
    else $error("halted result reports a side effect");

  a_mem_write_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == ST_CLEAR || state_q == ST_START ||
      state_q == ST_EXEC || state_q == ST_MEM))
    else $error("memory write outside a writing state");

endmodule

`default_nettype wire

// ===== dv/lc3b_executor_checker.sv =====
// checker for the lc3b executor: watches both channels, predicts and compares results
`timescale 1ns / 1ps
`default_nettype none

module lc3b_executor_checker
  import lc3b_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic        in_ready_i,
  input  wire in_t         in_req_i,
  input  wire logic        out_valid_i,
  input  wire logic        out_ready_i,
  input  wire out_t        out_res_i,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  output int               fail_count_o,
  output int               pending_o
);

  // machine state mirror
  logic [15:0] mem_words [MEM_WORDS];
  logic [15:0] regs [NUM_REGS];
  logic [15:0] pc_q;
  logic [2:0]  flags_q;
  logic [15:0] start_pc_q;
  out_t        expected_q [$];

  assign pending_o = expected_q.size();

  function automatic logic [MEM_AW-1:0] word_of(logic [15:0] byte_addr);
    return MEM_AW'(byte_addr >> 1);
  endfunction

  function automatic logic [15:0] sign_ext(logic [15:0] v, int bits);
    logic [15:0] r;
    r = v & ((16'd1 << bits) - 16'd1);
    if (r[bits-1]) r = r | ~((16'd1 << bits) - 16'd1);
    return r;
  endfunction

  function automatic logic [2:0] flags_of(logic [15:0] v);
    if (v == 16'd0) return FLAGS_Z;
    if (v[15]) return FLAGS_N;
    return FLAGS_P;
  endfunction

  // execute one request against the mirror and queue the result
  task automatic run_request(in_t req);
    out_t        r;
    logic [15:0] ir, npc, a, b, res, addr, link, by;
    logic [2:0]  dr;
    logic        wr, cc;
    logic [3:0]  amt;
    r = '0;
    r.mem_written = MW_NONE;
    case (action_e'(req.action))
      ACT_LOAD: mem_words[MEM_AW'(req.word_address)] = req.word_data;
      ACT_RESTART: begin
        for (int i = 0; i < NUM_REGS; i++) regs[i] = '0;
        pc_q = start_pc_q;
        flags_q = FLAGS_Z;
      end
      ACT_EXEC: begin
        if (pc_q == 16'd0) begin
          r.halted = 1'b1;
        end else begin
          ir  = mem_words[word_of(pc_q)];
          npc = pc_q + 16'd2;
          dr  = ir[11:9];
          a   = regs[ir[8:6]];
          b   = ir[5] ? sign_ext(ir, 5) : regs[ir[2:0]];
          res = '0;
          wr  = 1'b0;
          cc  = 1'b0;
          case (op_e'(ir[15:12]))
            OP_BR:
              if (|(ir[11:9] & flags_q)) npc = npc + (sign_ext(ir, 9) << 1);
            OP_ADD: begin res = a + b; wr = 1; cc = 1; end
            OP_AND: begin res = a & b; wr = 1; cc = 1; end
            OP_XOR: begin res = a ^ b; wr = 1; cc = 1; end
            OP_LDB: begin
              addr = a + sign_ext(ir, 6);
              res = mem_words[word_of(addr)];
              res = sign_ext(addr[0] ? (res >> 8) : res, 8);
              wr = 1; cc = 1;
            end
            OP_LDW: begin
              addr = a + (sign_ext(ir, 6) << 1);
              res = mem_words[word_of(addr)];
              wr = 1; cc = 1;
            end
            OP_STB: begin
              by = {8'd0, regs[dr][7:0]};
              addr = a + sign_ext(ir, 6);
              if (addr[0]) mem_words[word_of(addr)][15:8] = by[7:0];
              else mem_words[word_of(addr)][7:0] = by[7:0];
              r.mem_written = MW_BYTE;
              r.mem_byte_address = addr;
              r.mem_value = by;
            end
            OP_STW: begin
              addr = (a + (sign_ext(ir, 6) << 1)) & 16'hFFFE;
              mem_words[word_of(addr)] = regs[dr];
              r.mem_written = MW_WORD;
              r.mem_byte_address = addr;
              r.mem_value = regs[dr];
            end
            OP_JMP: npc = a;
            OP_JSR: begin
              link = npc;
              npc = ir[11] ? npc + (sign_ext(ir, 11) << 1) : a;
              dr = 3'd7; res = link; wr = 1;
            end
            OP_SHF: begin
              amt = ir[3:0];
              if (!ir[4]) res = a << amt;
              else if (ir[5]) res = 16'($signed(a) >>> amt);
              else res = a >> amt;
              wr = 1; cc = 1;
            end
            OP_LEA: begin res = npc + (sign_ext(ir, 9) << 1); wr = 1; end
            OP_TRAP: begin
              link = npc;
              npc = mem_words[MEM_AW'(ir[7:0])];
              dr = 3'd7; res = link; wr = 1;
            end
            default: ;
          endcase
          if (wr) begin
            regs[dr] = res;
            r.reg_written = 1'b1;
            r.reg_index = dr;
            r.reg_value = res;
          end
          if (cc) flags_q = flags_of(res);
          pc_q = npc;
        end
      end
      default: ;
    endcase
    r.program_counter = pc_q;
    {r.flag_negative, r.flag_zero, r.flag_positive} = flags_q;
    expected_q.push_back(r);
  endtask

  // compare one result field by field
  task automatic compare_result(out_t got);
    out_t e;
    if (expected_q.size() == 0) begin
      $error("result with no request pending: %h", got);
      fail_count_o++;
      return;
    end
    e = expected_q.pop_front();
    if (got.program_counter !== e.program_counter) begin
      $error("program_counter exp %h got %h", e.program_counter, got.program_counter);
      fail_count_o++;
    end
    if (got.flag_negative !== e.flag_negative) begin
      $error("flag_negative exp %b got %b", e.flag_negative, got.flag_negative);
      fail_count_o++;
    end
    if (got.flag_zero !== e.flag_zero) begin
      $error("flag_zero exp %b got %b", e.flag_zero, got.flag_zero);
      fail_count_o++;
    end
    if (got.flag_positive !== e.flag_positive) begin
      $error("flag_positive exp %b got %b", e.flag_positive, got.flag_positive);
      fail_count_o++;
    end
    if (got.halted !== e.halted) begin
      $error("halted exp %b got %b", e.halted, got.halted);
      fail_count_o++;
    end
    if (got.reg_written !== e.reg_written) begin
      $error("reg_written exp %b got %b", e.reg_written, got.reg_written);
      fail_count_o++;
    end
    if (got.reg_index !== e.reg_index) begin
      $error("reg_index exp %d got %d", e.reg_index, got.reg_index);
      fail_count_o++;
    end
    if (got.reg_value !== e.reg_value) begin
      $error("reg_value exp %h got %h", e.reg_value, got.reg_value);
      fail_count_o++;
    end
    if (got.mem_written !== e.mem_written) begin
      $error("mem_written exp %d got %d", e.mem_written, got.mem_written);
      fail_count_o++;
    end
    if (got.mem_byte_address !== e.mem_byte_address) begin
      $error("mem_byte_address exp %h got %h", e.mem_byte_address, got.mem_byte_address);
      fail_count_o++;
    end
    if (got.mem_value !== e.mem_value) begin
      $error("mem_value exp %h got %h", e.mem_value, got.mem_value);
      fail_count_o++;
    end
  endtask

  // mirror reset
  initial begin
    fail_count_o = 0;
    for (int i = 0; i < MEM_WORDS; i++) mem_words[i] = '0;
    for (int i = 0; i < NUM_REGS; i++) regs[i] = '0;
    pc_q = '0;
    flags_q = FLAGS_Z;
    start_pc_q = '0;
  end

  // sample both channels and the config port each edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) compare_result(out_res_i);
      if (in_valid_i && in_ready_i) run_request(in_req_i);
    end
    if (cfg_we_i) start_pc_q = cfg_wdata_i;
  end

  // end-of-run block, which does no check on leftover expected results
  final begin
  end

endmodule

`default_nettype wire

// ===== dv/lc3b_instruction_executor_top_tb.sv =====
// testbench top for the lc3b executor: stimulus, config phases and verdict
`timescale 1ns / 1ps
`default_nettype none

module lc3b_instruction_executor_top_tb;
  import lc3b_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_t         in_req;
  logic        out_valid;
  logic        out_ready;
  out_t        out_res;
  logic        cfg_we;
  logic [15:0] cfg_wdata;
  int          fail_count;
  int          pending;
  logic        stall_en;

  lc3b_instruction_executor_top i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_res_o   (out_res),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  lc3b_executor_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_req_i     (in_req),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_res_i    (out_res),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    if (!stall_en) return 0;
    if ($urandom_range(9) < 6) return 0;
    if ($urandom_range(9) < 8) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // result side stalls
  initial begin
    int g;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      g = gap_len();
      if (g > 0) begin
        out_ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // valid stays up across back-to-back requests and drops only for a gap
  task automatic send_request(action_e act, logic [14:0] waddr, logic [15:0] wdata);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= '{action: act, word_address: waddr, word_data: wdata};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic load_word(logic [14:0] waddr, logic [15:0] wdata);
    send_request(ACT_LOAD, waddr, wdata);
  endtask

  task automatic exec_one();
    send_request(ACT_EXEC, 15'($urandom), 16'($urandom));
  endtask

  // drain then write start pc while idle
  task automatic set_start_pc(logic [15:0] v);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // random instruction biased toward useful ones
  function automatic logic [15:0] rand_instr();
    logic [15:0] ir;
    ir = 16'($urandom);
    // keep control flow tame most of the time
    if (ir[15:12] inside {OP_JMP, OP_JSR, OP_TRAP} && $urandom_range(3) != 0)
      ir[15:12] = OP_ADD;
    if (ir[15:12] == OP_BR && $urandom_range(1)) ir[8:0] = 9'h1FF & 9'($urandom_range(6));
    return ir;
  endfunction

  // program at word base, four random trap vectors filled, then run it
  task automatic run_program(logic [15:0] base_pc, int n_instr, int n_exec);
    logic [14:0] w;
    w = 15'(base_pc >> 1);
    for (int i = 0; i < 4; i++) load_word(15'($urandom_range(255)), base_pc + 16'(2 * $urandom_range(n_instr)));
    for (int i = 0; i < n_instr; i++) load_word(w + 15'(i), rand_instr());
    send_request(ACT_RESTART, 15'($urandom), 16'($urandom));
    for (int i = 0; i < n_exec; i++) begin
      if ($urandom_range(15) == 0) send_request(ACT_NONE, 15'($urandom), 16'($urandom));
      else if ($urandom_range(20) == 0) send_request(ACT_RESTART, '0, '0);
      else exec_one();
    end
  endtask

  initial begin
    logic [15:0] sp;
    in_valid  = 1'b0;
    in_req    = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    stall_en  = 1'b0;
    rst_n     = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: halt at pc zero, extreme loads, most opcodes from 0x0100
    exec_one();
    load_word(15'h7FFF, 16'hFFFF);
    load_word(15'h0000, 16'h0000);
    set_start_pc(16'h0100);
    load_word(15'h0080, 16'h1262);   // add r1 = r1 + 2
    load_word(15'h0081, 16'h1240);   // add r1 = r1 + r0
    load_word(15'h0082, 16'h5460);   // and r2 = r1 & 0
    load_word(15'h0083, 16'h967F);   // not r3 = ~r1
    load_word(15'h0084, 16'hD8C4);   // lshf r4 = r3 << 4
    load_word(15'h0085, 16'hDAFF);   // rshfa r5 = r3 >>> 15
    load_word(15'h0086, 16'hDAEF);   // mode ten acts as lshf
    load_word(15'h0087, 16'h3A7F);   // stb r5 -> odd address
    load_word(15'h0088, 16'h2C7F);   // ldb back
    load_word(15'h0089, 16'h7A7F);   // stw with negative offset
    load_word(15'h008A, 16'h6C7F);   // ldw
    load_word(15'h008B, 16'hEE01);   // lea
    load_word(15'h008C, 16'h8000);   // rti as no-op
    load_word(15'h008D, 16'h0E00);   // br nzp +0
    load_word(15'h008E, 16'hF001);   // trap x01
    load_word(15'h0001, 16'h0120);
    load_word(15'h0090, 16'h41C0);   // jsrr through r7
    send_request(ACT_RESTART, '0, '0);
    repeat (16) exec_one();
    send_request(ACT_NONE, '0, '0);
    set_start_pc(16'h0001);           // odd start pc
    send_request(ACT_RESTART, '0, '0);
    exec_one();

    // random phases with idling
    stall_en = 1'b1;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: sp = 16'hFFFE;
        1: sp = 16'h0000;
        default: sp = 16'($urandom_range(16'h7FFF, 16'h0200)) & 16'hFFFE;
      endcase
      set_start_pc(sp);
      run_program(sp == 0 ? 16'h0200 : sp, 30, 140);
    end

    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule

`default_nettype wire

// ===== lc3b_instruction_executor_top.f =====
rtl/lc3b_pkg.sv
rtl/lc3b_ram.sv
rtl/lc3b_instruction_executor_top.sv
dv/lc3b_executor_checker.sv
dv/lc3b_instruction_executor_top_tb.sv
